// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Consequent holds in the cycle after antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/fddc_pkg.sv =====
package fddc_pkg;

	localparam int ONE_Q14 = 16384;

	typedef enum logic [2:0] {
		REG_SPIN_GAIN        = 3'd0,
		REG_WALL_LIMIT_X     = 3'd1,
		REG_NEAR_DISTANCE    = 3'd2,
		REG_MIN_DISTANCE     = 3'd3,
		REG_RETREAT_DISTANCE = 3'd4,
		REG_ESCAPE_LIMIT     = 3'd5,
		REG_PUSH_GAIN        = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_FZ, S_FZ_DIV, S_RC, S_R1, S_R2, S_RL, S_RR,
		S_DL, S_DL_DIV, S_DR, S_DR_DIV, S_OV, S_PUSH_DIV, S_SP, S_FIN
	} state_t;

	typedef struct packed {
		logic signed [63:0] area;
		logic signed [63:0] mom;
	} acc_t;

	// breakpoints, ball sets 0..4 then target sets 0..4
	localparam logic signed [15:0] FZ_PTS [10][4] = '{
		'{16'sd10240, 16'sd10240, 16'sd13107, 16'sd13107},
		'{16'sd2048, 16'sd4096, 16'sd9830, 16'sd10240},
		'{-16'sd3277, -16'sd2048, 16'sd2048, 16'sd3277},
		'{-16'sd9830, -16'sd8192, -16'sd4096, -16'sd2048},
		'{-16'sd13107, -16'sd13107, -16'sd10240, -16'sd9011},
		'{16'sd9011, 16'sd10240, 16'sd13107, 16'sd13107},
		'{16'sd2048, 16'sd4096, 16'sd8192, 16'sd9830},
		'{-16'sd3277, -16'sd2048, 16'sd2048, 16'sd3277},
		'{-16'sd9830, -16'sd8192, -16'sd4096, -16'sd2048},
		'{-16'sd13107, -16'sd13107, -16'sd10240, -16'sd9011}
	};

	// consequents [target][ball]
	localparam logic [1:0] RULE_L [5][5] = '{
		'{2'd1, 2'd2, 2'd3, 2'd3, 2'd1},
		'{2'd1, 2'd2, 2'd3, 2'd3, 2'd1},
		'{2'd0, 2'd0, 2'd3, 2'd3, 2'd0},
		'{2'd3, 2'd0, 2'd0, 2'd3, 2'd3},
		'{2'd1, 2'd2, 2'd3, 2'd3, 2'd1}
	};
	localparam logic [1:0] RULE_R [5][5] = '{
		'{2'd3, 2'd3, 2'd0, 2'd2, 2'd3},
		'{2'd3, 2'd3, 2'd0, 2'd0, 2'd3},
		'{2'd3, 2'd3, 2'd3, 2'd0, 2'd3},
		'{2'd1, 2'd3, 2'd3, 2'd2, 2'd1},
		'{2'd3, 2'd3, 2'd0, 2'd2, 2'd3}
	};

	// 6*area and 6*moment (tenths) of one clipped output set
	function automatic acc_t acc_terms(input logic [1:0] set, input logic [14:0] h,
		input logic [28:0] h2, input logic [42:0] h3);
		logic signed [63:0] a1;
		logic signed [63:0] a2;
		logic signed [63:0] a3;
		acc_t r;
		a1 = {21'b0, h, 28'b0};
		a2 = {21'b0, h2, 14'b0};
		a3 = {21'b0, h3};
		unique case (set)
			2'd0: begin
				r.area = a1 * 64'sd30 - a2 * 64'sd6;
				r.mom = a2 * 64'sd30 + a3 * 64'sd4 - a1 * 64'sd225;
			end
			2'd1: begin
				r.area = a1 * 64'sd42 - a2 * 64'sd12;
				r.mom = a2 * 64'sd30 - a1 * 64'sd105;
			end
			2'd2: begin
				r.area = a1 * 64'sd42 - a2 * 64'sd12;
				r.mom = a1 * 64'sd105 - a2 * 64'sd30;
			end
			default: begin
				r.area = a1 * 64'sd30 - a2 * 64'sd6;
				r.mom = a1 * 64'sd225 - a2 * 64'sd30 - a3 * 64'sd4;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/fuzzy_differential_drive_controller.sv =====
// Sequence: a divide per sloped membership (at most 4), S_R1, S_R2, S_RL and S_RR per fired
//   rule (at most 4), a divide per drive with a fired rule and one when obstacle push applies.
// Throughput: a new beat is taken only in S_IDLE, once the last has left S_FIN; a single
//   shared restoring divider (one quotient bit per cycle) and one rule accumulator limit it.
// Reset: arst_n clears the sequencer, output valid and escape counter and loads
//   the register defaults; no clearing pass.
module fuzzy_differential_drive_controller
	import fddc_pkg::*;
#(
	parameter int ESCAPE_COUNT_MAX = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// ball_angle, target_angle, spin_rate, obstacle_distance, obstacle_angle, robot_x
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// left_drive, right_drive, left_no_rule, right_no_rule, 6'b0
	output logic [39:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CW = $clog2(ESCAPE_COUNT_MAX + 1);

	state_t state_q, state_d;

	logic [11:0] spin_gain_q;
	logic [14:0] wall_limit_x_q;
	logic [15:0] near_distance_q, min_distance_q, retreat_distance_q, push_gain_q;
	logic [7:0]  escape_limit_q;
	logic [CW-1:0] cnt_q;

	logic signed [15:0] ba_q, ta_q, sp_q, oa_q, rx_q;
	logic [15:0] dist_q;
	logic [14:0] bd_q [5];
	logic [14:0] td_q [5];
	logic [3:0]  k_q;
	logic [2:0]  i_q, j_q;
	logic [14:0] h_q;
	logic [28:0] h2_q;
	logic [42:0] h3_q;
	logic signed [63:0] la_q, lm_q, ra_q, rm_q;
	logic signed [31:0] lf_q, rf_q;
	logic signed [22:0] p_q;
	logic [15:0] d_q;
	logic        neg_q;

	logic [57:0] div_rem_q, div_den_q;
	logic [71:0] div_quo_q;
	logic [6:0]  div_cnt_q;
	logic        div_busy;
	logic        div_start;
	logic [71:0] div_num;
	logic [57:0] div_den;
	logic [6:0]  div_n;
	logic [58:0] rem_sh;

	logic        m_valid_q;
	logic [15:0] out_l_q, out_r_q;
	logic        lnr_q, rnr_q;
	logic        lnr_out_q, rnr_out_q;

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = {6'b0, rnr_out_q, lnr_out_q, out_r_q, out_l_q};
	assign div_busy = (div_cnt_q != 7'd0);

	// membership of current set
	logic signed [15:0] fx, p0, p1, p2, p3;
	logic fz_zero, fz_full, fz_up;
	logic signed [16:0] fz_num, fz_den;
	always_comb begin
		fx = (k_q < 4'd5) ? ba_q : ta_q;
		p0 = FZ_PTS[k_q][0];
		p1 = FZ_PTS[k_q][1];
		p2 = FZ_PTS[k_q][2];
		p3 = FZ_PTS[k_q][3];
		fz_zero = (fx >= p3) || (fx <= p0);
		fz_full = (fx > p1) && (fx < p2);
		fz_up = !(fx > p1);
		fz_num = fz_up ? (17'(fx) - 17'(p0)) : (17'(p3) - 17'(fx));
		fz_den = fz_up ? (17'(p1) - 17'(p0)) : (17'(p3) - 17'(p2));
	end

	logic [14:0] rb, rt, rh;
	logic rule_fire, rule_last, fz_last;
	always_comb begin
		rb = bd_q[i_q];
		rt = td_q[j_q];
		rh = (rb < rt) ? rb : rt;
		rule_fire = (rb != 15'd0) && (rt != 15'd0);
		rule_last = (i_q == 3'd4) && (j_q == 3'd4);
		fz_last = (k_q == 4'd9);
	end

	// override conditions
	logic signed [16:0] rx17, wl17;
	logic wall, near, near_a, near_b;
	logic [15:0] d_fl;
	logic [16:0] cnt_x, lim_x;
	logic [CW-1:0] cnt_up;
	always_comb begin
		rx17 = {rx_q[15], rx_q};
		wl17 = {2'b0, wall_limit_x_q};
		wall = (rx17 < -wl17) || (rx17 > wl17);
		near = dist_q < near_distance_q;
		near_a = near && (oa_q < 16'sd3277) && (oa_q > -16'sd3277);
		cnt_x = 17'(cnt_q);
		lim_x = 17'(escape_limit_q);
		near_b = near && (oa_q < 16'sd8192) && (oa_q > -16'sd8192) && (cnt_x > lim_x);
		d_fl = (dist_q < min_distance_q) ? min_distance_q : dist_q;
		if (d_fl == 16'd0) begin
			d_fl = 16'd1;
		end
		cnt_up = (cnt_x < 17'(ESCAPE_COUNT_MAX)) ? cnt_q + CW'(1) : cnt_q;
	end

	logic [63:0] lm_abs, rm_abs;
	assign lm_abs = lm_q[63] ? 64'(-lm_q) : 64'(lm_q);
	assign rm_abs = rm_q[63] ? 64'(-rm_q) : 64'(rm_q);

	logic [19:0] q_rnd;
	assign q_rnd = (div_quo_q[19:0] + 20'd1) >> 1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_FZ;
			end
			S_FZ: begin
				if (!fz_zero && !fz_full) state_d = S_FZ_DIV;
				else if (fz_last) state_d = S_RC;
			end
			S_FZ_DIV: begin
				if (!div_busy) state_d = fz_last ? S_RC : S_FZ;
			end
			S_RC: begin
				if (rule_fire) state_d = S_R1;
				else if (rule_last) state_d = S_DL;
			end
			S_R1: state_d = S_R2;
			S_R2: state_d = S_RL;
			S_RL: state_d = S_RR;
			S_RR: state_d = rule_last ? S_DL : S_RC;
			S_DL: state_d = (la_q == 64'sd0) ? S_DR : S_DL_DIV;
			S_DL_DIV: begin
				if (!div_busy) state_d = S_DR;
			end
			S_DR: state_d = (ra_q == 64'sd0) ? S_OV : S_DR_DIV;
			S_DR_DIV: begin
				if (!div_busy) state_d = S_OV;
			end
			S_OV: state_d = (!wall && near_a) ? S_PUSH_DIV : S_SP;
			S_PUSH_DIV: begin
				if (!div_busy) state_d = S_SP;
			end
			S_SP: state_d = S_FIN;
			S_FIN: begin
				if (!m_valid_q || m_tready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		div_n = 7'd32;
		unique case (state_q)
			S_FZ: begin
				div_start = !fz_zero && !fz_full;
				div_num = {18'(fz_num), 14'b0, 40'b0};
				div_den = 58'(fz_den);
			end
			S_DL: begin
				div_start = (la_q != 64'sd0);
				div_num = {lm_abs[56:0], 15'b0};
				div_den = 58'(la_q[53:0]) * 58'd10;
				div_n = 7'd72;
			end
			S_DR: begin
				div_start = (ra_q != 64'sd0);
				div_num = {rm_abs[56:0], 15'b0};
				div_den = 58'(ra_q[53:0]) * 58'd10;
				div_n = 7'd72;
			end
			S_OV: begin
				div_start = !wall && near_a;
				div_num = {6'b0, push_gain_q, 10'b0, 40'b0};
				div_den = 58'(d_fl);
			end
			default: ;
		endcase
	end

	// shared restoring divider, one quotient bit per cycle
	assign rem_sh = {div_rem_q, div_quo_q[71]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= 7'd0;
		end else if (div_start) begin
			div_cnt_q <= div_n;
		end else if (div_busy) begin
			div_cnt_q <= div_cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			div_rem_q <= '0;
			div_quo_q <= div_num;
			div_den_q <= div_den;
		end else if (div_busy) begin
			if (rem_sh >= {1'b0, div_den_q}) begin
				div_rem_q <= 58'(rem_sh - {1'b0, div_den_q});
				div_quo_q <= {div_quo_q[70:0], 1'b1};
			end else begin
				div_rem_q <= rem_sh[57:0];
				div_quo_q <= {div_quo_q[70:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_gain_q <= 12'd1024;
			wall_limit_x_q <= 15'd11840;
			near_distance_q <= 16'd640;
			min_distance_q <= 16'd80;
			retreat_distance_q <= 16'd160;
			escape_limit_q <= 8'd40;
			push_gain_q <= 16'd2560;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SPIN_GAIN: spin_gain_q <= cfg_data[11:0];
				REG_WALL_LIMIT_X: wall_limit_x_q <= cfg_data[14:0];
				REG_NEAR_DISTANCE: near_distance_q <= cfg_data;
				REG_MIN_DISTANCE: min_distance_q <= cfg_data;
				REG_RETREAT_DISTANCE: retreat_distance_q <= cfg_data;
				REG_ESCAPE_LIMIT: escape_limit_q <= cfg_data[7:0];
				REG_PUSH_GAIN: push_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (state_q == S_OV) begin
				priority if (wall) begin
					if (cnt_x < lim_x) cnt_q <= cnt_up;
				end else if (near_a) begin
					cnt_q <= cnt_up;
				end else if (near_b) begin
					cnt_q <= cnt_q - CW'(1);
				end else begin
					cnt_q <= '0;
				end
			end else if (state_q == S_PUSH_DIV && !div_busy) begin
				if (cnt_x > lim_x && d_q > retreat_distance_q) cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	acc_t acc_l, acc_r;
	assign acc_l = acc_terms(RULE_L[j_q][i_q], h_q, h2_q, h3_q);
	assign acc_r = acc_terms(RULE_R[j_q][i_q], h_q, h2_q, h3_q);

	logic signed [28:0] spin_prod;
	logic signed [32:0] sum_l, sum_r;
	assign spin_prod = sp_q * $signed({1'b0, spin_gain_q});
	assign sum_l = 33'(lf_q) + 33'(p_q);
	assign sum_r = 33'(rf_q) - 33'(p_q);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ba_q <= s_tdata[15:0];
				ta_q <= s_tdata[31:16];
				sp_q <= s_tdata[47:32];
				dist_q <= s_tdata[63:48];
				oa_q <= s_tdata[79:64];
				rx_q <= s_tdata[95:80];
				k_q <= 4'd0;
				i_q <= 3'd0;
				j_q <= 3'd0;
				la_q <= '0;
				lm_q <= '0;
				ra_q <= '0;
				rm_q <= '0;
			end
			S_FZ, S_FZ_DIV: begin
				if (state_q == S_FZ_DIV ? !div_busy : (fz_zero || fz_full)) begin
					if (k_q < 4'd5) begin
						bd_q[k_q[2:0]] <= (state_q == S_FZ_DIV) ? div_quo_q[14:0] :
							(fz_full ? 15'(ONE_Q14) : 15'd0);
					end else begin
						td_q[3'(k_q - 4'd5)] <= (state_q == S_FZ_DIV) ? div_quo_q[14:0] :
							(fz_full ? 15'(ONE_Q14) : 15'd0);
					end
					k_q <= k_q + 4'd1;
				end
			end
			S_RC, S_RR: begin
				if (state_q == S_RC) h_q <= rh;
				else begin
					ra_q <= ra_q + acc_r.area;
					rm_q <= rm_q + acc_r.mom;
				end
				if (state_q == S_RR || !rule_fire) begin
					if (i_q == 3'd4) begin
						i_q <= 3'd0;
						j_q <= j_q + 3'd1;
					end else begin
						i_q <= i_q + 3'd1;
					end
				end
			end
			S_R1: h2_q <= 29'(h_q) * 29'(h_q);
			S_R2: h3_q <= 43'(h2_q) * 43'(h_q);
			S_RL: begin
				la_q <= la_q + acc_l.area;
				lm_q <= lm_q + acc_l.mom;
			end
			S_DL: begin
				lf_q <= '0;
				lnr_q <= (la_q == 64'sd0);
				neg_q <= lm_q[63];
			end
			S_DL_DIV: begin
				if (!div_busy) lf_q <= neg_q ? -32'(q_rnd) : 32'(q_rnd);
			end
			S_DR: begin
				rf_q <= '0;
				rnr_q <= (ra_q == 64'sd0);
				neg_q <= rm_q[63];
			end
			S_DR_DIV: begin
				if (!div_busy) rf_q <= neg_q ? -32'(q_rnd) : 32'(q_rnd);
			end
			S_OV: begin
				d_q <= d_fl;
				priority if (wall) begin
					if (!(cnt_x < lim_x)) begin
						lf_q <= -32'sd16384;
						rf_q <= -32'sd16384;
					end
				end else if (near_a) begin
				end else if (near_b) begin
					lf_q <= 32'sd16384;
					rf_q <= 32'sd16384;
				end
			end
			S_PUSH_DIV: begin
				if (!div_busy) begin
					if (cnt_x > lim_x && d_q > retreat_distance_q) begin
						lf_q <= -32'sd16384;
						rf_q <= -32'sd16384;
					end else if (oa_q < 0) begin
						lf_q <= lf_q - 32'(div_quo_q[26:0]);
					end else begin
						rf_q <= rf_q - 32'(div_quo_q[26:0]);
					end
				end
			end
			S_SP: p_q <= spin_prod[28:6];
			S_FIN: begin
				if (!m_valid_q || m_tready) begin
					out_l_q <= (sum_l > 33'sd16384) ? 16'sd16384 :
						(sum_l < -33'sd16384) ? -16'sd16384 : sum_l[15:0];
					out_r_q <= (sum_r > 33'sd16384) ? 16'sd16384 :
						(sum_r < -33'sd16384) ? -16'sd16384 : sum_r[15:0];
					lnr_out_q <= lnr_q;
					rnr_out_q <= rnr_q;
				end
			end
			default: ;
		endcase
	end

`include "assert_macros.svh"

	`ASSERT_NEXT(a_busy_after_beat, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`ASSERT_HOLDS(a_div_no_restart, clk, arst_n, !(div_start && div_busy))
	`ASSERT_HOLDS(a_cnt_max, clk, arst_n, 17'(cnt_q) <= 17'(ESCAPE_COUNT_MAX))
	`ASSERT_HOLDS(a_drive_range, clk, arst_n, !m_tvalid || ($signed(m_tdata[15:0]) <= 16'sd16384 && $signed(m_tdata[15:0]) >= -16'sd16384))

endmodule
